FILE: sv/nupz_pkg.sv
// ----------------------------------------------------------------------------
// nupz_pkg
// shared widths, codes and pipeline payload types of the neutrino pz unit
// ----------------------------------------------------------------------------
package nupz_pkg;

    // momentum field width, most of the widths below follow from it
    localparam int MOM_BITS = 17;
    localparam int W_BITS   = 12;
    localparam int OUT_BITS = 24;

    localparam logic [W_BITS-1:0] W_RESET = 12'd1286;

    localparam int SQ_W  = 2 * MOM_BITS;      // squares, P and M
    localparam int W2_W  = 2 * W_BITS;        // w_mass squared
    localparam int L_W   = 2 * MOM_BITS + 3;  // signed 2*lambda
    localparam int LM_W  = 2 * MOM_BITS + 2;  // magnitude of 2*lambda
    localparam int LH_W  = LM_W / 2;          // low half for the split multiply
    localparam int PM_W  = 2 * SQ_W;          // P*M
    localparam int D_W   = 2 * LM_W;          // discriminant
    localparam int R_W   = D_W / 2;           // integer root
    localparam int RM_W  = R_W + 2;           // root remainder
    localparam int RP_W  = MOM_BITS + R_W;    // energy times root
    localparam int C_W   = LM_W + MOM_BITS;   // |2*lambda * lep_pz|
    localparam int B_W   = ((C_W > RP_W) ? C_W : RP_W) + 1;
    localparam int N_W   = B_W + 1;           // rounded numerator
    localparam int DV_W  = SQ_W + 1;          // divisor 2*P

    localparam int IN_TDATA_W   = ((6 * MOM_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((2 * OUT_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = 3;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_W_MASS = '0;

    localparam logic [OUT_BITS-1:0] POS_LIMIT = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] NEG_LIMIT = {1'b1, {(OUT_BITS-1){1'b0}}};

    typedef enum logic [1:0]
    {
        STAT_REAL    = 2'd0,
        STAT_COMPLEX = 2'd1,
        STAT_PT_ZERO = 2'd2
    } status_t;

    // payload of one square root stage
    typedef struct packed
    {
        status_t               status;
        logic [MOM_BITS-1:0]   en;
        logic [C_W-1:0]        c;
        logic                  cneg;
        logic [SQ_W-1:0]       p;
        logic [D_W-1:0]        d;
        logic [RM_W-1:0]       rem;
        logic [R_W-1:0]        root;
    } sq_t;

    // payload of one divider stage, both roots side by side
    typedef struct packed
    {
        status_t               status;
        logic [DV_W-1:0]       dvsr;
        logic                  sneg;
        logic                  bneg;
        logic                  sovf;
        logic                  bovf;
        logic [DV_W-1:0]       srem;
        logic [DV_W-1:0]       brem;
        logic [OUT_BITS-1:0]   snum;
        logic [OUT_BITS-1:0]   bnum;
        logic [OUT_BITS-1:0]   sq;
        logic [OUT_BITS-1:0]   bq;
    } dv_t;

endpackage

FILE: sv/neutrino_pz_from_w_mass.sv
// ----------------------------------------------------------------------------
// neutrino_pz_from_w_mass
// neutrino longitudinal momentum from the w mass constraint, fully pipelined
// ----------------------------------------------------------------------------
//
//  channel   | direction | contents
//  ----------+-----------+-------------------------------------------------
//  s_axis    | in        | lepton px, py, pz, energy, met px, py
//  m_axis    | out       | pz_small, pz_other (tdata), status, saturated (tuser)
//  apb       | in/out    | w_mass register at byte address 0
//
//  one transaction enters per cycle unless a stall holds the pipeline; each
//  result passes through the one-bit-per-stage root and the one-bit-per-stage
//  dividers
//  rst_n clears valid bits, the output stage and w_mass (1286, 80.4 GeV)
//  a stall on m_axis fills a skid register first; the whole pipeline then
//  holds, so nothing is lost or repeated
// ----------------------------------------------------------------------------
module neutrino_pz_from_w_mass
    import nupz_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // lep_px, lep_py, lep_pz, lep_energy, met_px, met_py from bit 0 up
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // pz_small, pz_other from bit 0 up
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    // status, saturated from bit 0 up
    output logic [OUT_TUSER_W-1:0]  m_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    // stage indices of the valid shift register
    localparam int I_SQ0 = 5;
    localparam int I_R   = I_SQ0 + R_W + 1;
    localparam int I_BS  = I_R + 1;
    localparam int I_N   = I_BS + 1;
    localparam int I_DV0 = I_N + 1;
    localparam int NSTG  = I_DV0 + OUT_BITS + 1;

    localparam int OUT_W = OUT_BITS + OUT_BITS + OUT_TUSER_W;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [W_BITS-1:0] w_mass_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_W_MASS);
    assign prdata = (paddr[ADDR_W-1:2] == REG_W_MASS) ? DATA_W'(w_mass_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            w_mass_reg <= W_RESET;
        else if (cfg_wr)
            w_mass_reg <= pwdata[W_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // pipeline control: global enable, released by the skid register
    // ------------------------------------------------------------------
    logic            pipe_en;
    logic [NSTG-1:0] vld_reg;
    logic            skid_v_reg;

    assign pipe_en  = !skid_v_reg;
    assign s_tready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (pipe_en)
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
    end

    // ------------------------------------------------------------------
    // stage 0: squares and transverse products
    // ------------------------------------------------------------------
    logic signed [MOM_BITS-1:0] in_lpx, in_lpy, in_lpz, in_mpx, in_mpy;
    logic        [MOM_BITS-1:0] in_en;
    logic signed [SQ_W-1:0]     in_lpx2, in_lpy2, in_mpx2, in_mpy2, in_dx, in_dy;

    assign in_lpx = $signed(s_tdata[0*MOM_BITS +: MOM_BITS]);
    assign in_lpy = $signed(s_tdata[1*MOM_BITS +: MOM_BITS]);
    assign in_lpz = $signed(s_tdata[2*MOM_BITS +: MOM_BITS]);
    assign in_en  = s_tdata[3*MOM_BITS +: MOM_BITS];
    assign in_mpx = $signed(s_tdata[4*MOM_BITS +: MOM_BITS]);
    assign in_mpy = $signed(s_tdata[5*MOM_BITS +: MOM_BITS]);

    assign in_lpx2 = SQ_W'(in_lpx) * SQ_W'(in_lpx);
    assign in_lpy2 = SQ_W'(in_lpy) * SQ_W'(in_lpy);
    assign in_mpx2 = SQ_W'(in_mpx) * SQ_W'(in_mpx);
    assign in_mpy2 = SQ_W'(in_mpy) * SQ_W'(in_mpy);
    assign in_dx   = SQ_W'(in_lpx) * SQ_W'(in_mpx);
    assign in_dy   = SQ_W'(in_lpy) * SQ_W'(in_mpy);

    logic        [SQ_W-1:0]     s0_lpx2_reg, s0_lpy2_reg, s0_mpx2_reg, s0_mpy2_reg;
    logic signed [SQ_W-1:0]     s0_dx_reg, s0_dy_reg;
    logic        [W2_W-1:0]     s0_w2_reg;
    logic        [MOM_BITS-1:0] s0_en_reg;
    logic signed [MOM_BITS-1:0] s0_lpz_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s0_lpx2_reg <= $unsigned(in_lpx2);
            s0_lpy2_reg <= $unsigned(in_lpy2);
            s0_mpx2_reg <= $unsigned(in_mpx2);
            s0_mpy2_reg <= $unsigned(in_mpy2);
            s0_dx_reg   <= in_dx;
            s0_dy_reg   <= in_dy;
            s0_w2_reg   <= W2_W'(w_mass_reg) * W2_W'(w_mass_reg);
            s0_en_reg   <= in_en;
            s0_lpz_reg  <= in_lpz;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: P, M and 2*lambda
    // ------------------------------------------------------------------
    logic signed [L_W-1:0] s1_l2_next;

    assign s1_l2_next = $signed({{(L_W-W2_W){1'b0}}, s0_w2_reg})
                      + ((L_W'(s0_dx_reg) + L_W'(s0_dy_reg)) <<< 1);

    logic        [SQ_W-1:0]     s1_p_reg, s1_m_reg;
    logic signed [L_W-1:0]      s1_l2_reg;
    logic        [MOM_BITS-1:0] s1_en_reg;
    logic signed [MOM_BITS-1:0] s1_lpz_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_p_reg   <= s0_lpx2_reg + s0_lpy2_reg;
            s1_m_reg   <= s0_mpx2_reg + s0_mpy2_reg;
            s1_l2_reg  <= s1_l2_next;
            s1_en_reg  <= s0_en_reg;
            s1_lpz_reg <= s0_lpz_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: magnitudes and signs
    // ------------------------------------------------------------------
    logic [LM_W-1:0]     s2_l2m_reg;
    logic                s2_l2neg_reg;
    logic [MOM_BITS-1:0] s2_lpzm_reg;
    logic                s2_lpzneg_reg;
    logic                s2_pzero_reg;
    logic [SQ_W-1:0]     s2_p_reg, s2_m_reg;
    logic [MOM_BITS-1:0] s2_en_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s2_l2m_reg    <= s1_l2_reg[L_W-1] ? LM_W'(-s1_l2_reg) : LM_W'(s1_l2_reg);
            s2_l2neg_reg  <= s1_l2_reg[L_W-1];
            s2_lpzm_reg   <= s1_lpz_reg[MOM_BITS-1] ? MOM_BITS'(-s1_lpz_reg)
                                                    : MOM_BITS'(s1_lpz_reg);
            s2_lpzneg_reg <= s1_lpz_reg[MOM_BITS-1];
            s2_pzero_reg  <= (s1_p_reg == '0);
            s2_p_reg      <= s1_p_reg;
            s2_m_reg      <= s1_m_reg;
            s2_en_reg     <= s1_en_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: partial products of lambda^2 and P*M, and lambda*pz
    // ------------------------------------------------------------------
    logic [LH_W+LM_W-1:0]     s3_lsq_lo_reg, s3_lsq_hi_reg;
    logic [MOM_BITS+SQ_W-1:0] s3_pm_lo_reg, s3_pm_hi_reg;
    logic [C_W-1:0]           s3_c_reg;
    logic                     s3_cneg_reg;
    logic                     s3_pzero_reg;
    logic [SQ_W-1:0]          s3_p_reg;
    logic [MOM_BITS-1:0]      s3_en_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s3_lsq_lo_reg <= (LH_W+LM_W)'(s2_l2m_reg[LH_W-1:0])
                             * (LH_W+LM_W)'(s2_l2m_reg);
            s3_lsq_hi_reg <= (LH_W+LM_W)'(s2_l2m_reg[LM_W-1:LH_W])
                             * (LH_W+LM_W)'(s2_l2m_reg);
            s3_pm_lo_reg  <= (MOM_BITS+SQ_W)'(s2_p_reg[MOM_BITS-1:0])
                             * (MOM_BITS+SQ_W)'(s2_m_reg);
            s3_pm_hi_reg  <= (MOM_BITS+SQ_W)'(s2_p_reg[SQ_W-1:MOM_BITS])
                             * (MOM_BITS+SQ_W)'(s2_m_reg);
            s3_c_reg      <= C_W'(s2_l2m_reg) * C_W'(s2_lpzm_reg);
            // sign only counts when neither factor is zero
            s3_cneg_reg   <= (s2_l2neg_reg != s2_lpzneg_reg)
                             && (s2_l2m_reg != '0) && (s2_lpzm_reg != '0);
            s3_pzero_reg  <= s2_pzero_reg;
            s3_p_reg      <= s2_p_reg;
            s3_en_reg     <= s2_en_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: sum the partial products
    // ------------------------------------------------------------------
    logic [D_W-1:0]      s4_lsq_reg, s4_pm4_reg;
    logic [PM_W-1:0]     s4_pm;
    logic [C_W-1:0]      s4_c_reg;
    logic                s4_cneg_reg;
    logic                s4_pzero_reg;
    logic [SQ_W-1:0]     s4_p_reg;
    logic [MOM_BITS-1:0] s4_en_reg;

    assign s4_pm = (PM_W'(s3_pm_hi_reg) << MOM_BITS) + PM_W'(s3_pm_lo_reg);

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s4_lsq_reg   <= (D_W'(s3_lsq_hi_reg) << LH_W) + D_W'(s3_lsq_lo_reg);
            s4_pm4_reg   <= D_W'({s4_pm, 2'b00});
            s4_c_reg     <= s3_c_reg;
            s4_cneg_reg  <= s3_cneg_reg;
            s4_pzero_reg <= s3_pzero_reg;
            s4_p_reg     <= s3_p_reg;
            s4_en_reg    <= s3_en_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: classify and form the discriminant, seed the root
    // ------------------------------------------------------------------
    sq_t sq_reg [0:R_W];
    sq_t sq_next [0:R_W];

    always_comb
    begin
        sq_next[0].en   = s4_en_reg;
        sq_next[0].c    = s4_c_reg;
        sq_next[0].cneg = s4_cneg_reg;
        sq_next[0].p    = s4_p_reg;
        sq_next[0].rem  = '0;
        sq_next[0].root = '0;
        sq_next[0].d    = '0;
        if (s4_pzero_reg)
            sq_next[0].status = STAT_PT_ZERO;
        else if ((s4_en_reg == '0) || (s4_lsq_reg <= s4_pm4_reg))
            sq_next[0].status = STAT_COMPLEX;
        else
        begin
            sq_next[0].status = STAT_REAL;
            sq_next[0].d      = s4_lsq_reg - s4_pm4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            sq_reg[0] <= sq_next[0];
    end

    // ------------------------------------------------------------------
    // integer square root, one result bit per stage
    // ------------------------------------------------------------------
    for (genvar k = 1; k <= R_W; k++)
    begin : g_sqrt
        logic [RM_W+1:0] trem;
        logic [RM_W+1:0] trial;
        logic            ge;

        assign trem  = {sq_reg[k-1].rem, sq_reg[k-1].d[D_W-1 -: 2]};
        assign trial = (RM_W+2)'({sq_reg[k-1].root, 2'b01});
        assign ge    = (trem >= trial);

        always_comb
        begin
            sq_next[k]      = sq_reg[k-1];
            sq_next[k].d    = sq_reg[k-1].d << 2;
            sq_next[k].rem  = ge ? RM_W'(trem - trial) : RM_W'(trem);
            sq_next[k].root = {sq_reg[k-1].root[R_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
                sq_reg[k] <= sq_next[k];
        end
    end

    // ------------------------------------------------------------------
    // root times energy
    // ------------------------------------------------------------------
    logic [RP_W-1:0] sr_r_reg;
    logic [C_W-1:0]  sr_c_reg;
    logic            sr_cneg_reg;
    logic [SQ_W-1:0] sr_p_reg;
    status_t         sr_status_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sr_r_reg      <= RP_W'(sq_reg[R_W].en) * RP_W'(sq_reg[R_W].root);
            sr_c_reg      <= sq_reg[R_W].c;
            sr_cneg_reg   <= sq_reg[R_W].cneg;
            sr_p_reg      <= sq_reg[R_W].p;
            sr_status_reg <= sq_reg[R_W].status;
        end
    end

    // ------------------------------------------------------------------
    // big and small numerator magnitudes with their signs
    // ------------------------------------------------------------------
    logic            bs_c_ge;
    logic [B_W-1:0]  bs_big_reg, bs_small_reg;
    logic            bs_bneg_reg, bs_sneg_reg;
    logic [SQ_W-1:0] bs_p_reg;
    status_t         bs_status_reg;

    assign bs_c_ge = (B_W'(sr_c_reg) >= B_W'(sr_r_reg));

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            bs_big_reg    <= B_W'(sr_c_reg) + B_W'(sr_r_reg);
            bs_small_reg  <= bs_c_ge ? (B_W'(sr_c_reg) - B_W'(sr_r_reg))
                                     : (B_W'(sr_r_reg) - B_W'(sr_c_reg));
            bs_bneg_reg   <= sr_cneg_reg;
            bs_sneg_reg   <= bs_c_ge ? sr_cneg_reg : !sr_cneg_reg;
            bs_p_reg      <= sr_p_reg;
            bs_status_reg <= sr_status_reg;
        end
    end

    // ------------------------------------------------------------------
    // add P for round to nearest, ties away from zero
    // ------------------------------------------------------------------
    logic [N_W-1:0]  n_s_reg, n_b_reg;
    logic [DV_W-1:0] n_dvsr_reg;
    logic            n_sneg_reg, n_bneg_reg;
    status_t         n_status_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            n_s_reg      <= N_W'(bs_small_reg) + N_W'(bs_p_reg);
            n_b_reg      <= N_W'(bs_big_reg) + N_W'(bs_p_reg);
            n_dvsr_reg   <= {bs_p_reg, 1'b0};
            n_sneg_reg   <= bs_sneg_reg;
            n_bneg_reg   <= bs_bneg_reg;
            n_status_reg <= bs_status_reg;
        end
    end

    // ------------------------------------------------------------------
    // overflow check: a quotient of 2^OUT_BITS or more saturates anyway
    // ------------------------------------------------------------------
    dv_t            dv_reg [0:OUT_BITS];
    dv_t            dv_next [0:OUT_BITS];
    logic [N_W-1:0] ov_hs, ov_hb;

    assign ov_hs = n_s_reg >> OUT_BITS;
    assign ov_hb = n_b_reg >> OUT_BITS;

    always_comb
    begin
        dv_next[0].status = n_status_reg;
        dv_next[0].dvsr   = n_dvsr_reg;
        dv_next[0].sneg   = n_sneg_reg;
        dv_next[0].bneg   = n_bneg_reg;
        dv_next[0].sovf   = (ov_hs >= N_W'(n_dvsr_reg));
        dv_next[0].bovf   = (ov_hb >= N_W'(n_dvsr_reg));
        dv_next[0].srem   = DV_W'(ov_hs);
        dv_next[0].brem   = DV_W'(ov_hb);
        dv_next[0].snum   = n_s_reg[OUT_BITS-1:0];
        dv_next[0].bnum   = n_b_reg[OUT_BITS-1:0];
        dv_next[0].sq     = '0;
        dv_next[0].bq     = '0;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            dv_reg[0] <= dv_next[0];
    end

    // ------------------------------------------------------------------
    // restoring dividers, one quotient bit per stage for both roots
    // ------------------------------------------------------------------
    for (genvar j = 1; j <= OUT_BITS; j++)
    begin : g_div
        logic [DV_W:0] ts, tb, dv1;
        logic          ges, geb;

        assign dv1 = {1'b0, dv_reg[j-1].dvsr};
        assign ts  = {dv_reg[j-1].srem, dv_reg[j-1].snum[OUT_BITS-1]};
        assign tb  = {dv_reg[j-1].brem, dv_reg[j-1].bnum[OUT_BITS-1]};
        assign ges = (ts >= dv1);
        assign geb = (tb >= dv1);

        always_comb
        begin
            dv_next[j]      = dv_reg[j-1];
            dv_next[j].srem = ges ? DV_W'(ts - dv1) : DV_W'(ts);
            dv_next[j].brem = geb ? DV_W'(tb - dv1) : DV_W'(tb);
            dv_next[j].snum = dv_reg[j-1].snum << 1;
            dv_next[j].bnum = dv_reg[j-1].bnum << 1;
            dv_next[j].sq   = {dv_reg[j-1].sq[OUT_BITS-2:0], ges};
            dv_next[j].bq   = {dv_reg[j-1].bq[OUT_BITS-2:0], geb};
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
                dv_reg[j] <= dv_next[j];
        end
    end

    // ------------------------------------------------------------------
    // clip, apply sign, zero the roots unless real
    // ------------------------------------------------------------------
    dv_t                 fin;
    logic [OUT_BITS-1:0] fin_slim, fin_blim, fin_smag, fin_bmag;
    logic                fin_ssat, fin_bsat;
    logic [OUT_BITS-1:0] fin_spz, fin_bpz;
    logic                fin_sat;
    logic [OUT_W-1:0]    fin_word;

    assign fin      = dv_reg[OUT_BITS];
    assign fin_slim = fin.sneg ? NEG_LIMIT : POS_LIMIT;
    assign fin_blim = fin.bneg ? NEG_LIMIT : POS_LIMIT;
    assign fin_ssat = fin.sovf || (fin.sq > fin_slim);
    assign fin_bsat = fin.bovf || (fin.bq > fin_blim);
    assign fin_smag = fin_ssat ? fin_slim : fin.sq;
    assign fin_bmag = fin_bsat ? fin_blim : fin.bq;

    always_comb
    begin
        fin_spz = '0;
        fin_bpz = '0;
        fin_sat = 1'b0;
        if (fin.status == STAT_REAL)
        begin
            fin_spz = fin.sneg ? -fin_smag : fin_smag;
            fin_bpz = fin.bneg ? -fin_bmag : fin_bmag;
            fin_sat = fin_ssat || fin_bsat;
        end
    end

    assign fin_word = {fin_sat, fin.status, fin_bpz, fin_spz};

    // ------------------------------------------------------------------
    // output register with skid register
    // ------------------------------------------------------------------
    logic             out_v_reg;
    logic [OUT_W-1:0] out_reg, skid_reg;
    logic             incoming;

    assign incoming = vld_reg[NSTG-1] && pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || m_tready)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
                out_v_reg <= incoming;
        end
        else if (incoming)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || m_tready)
            out_reg <= skid_v_reg ? skid_reg : fin_word;
        if (out_v_reg && !m_tready && incoming)
            skid_reg <= fin_word;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = OUT_TDATA_W'(out_reg[2*OUT_BITS-1:0]);
    assign m_tuser  = out_reg[OUT_W-1:2*OUT_BITS];

`ifndef SYNTHESIS
    // skid holds data only behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> m_tvalid)
        else $error("skid register full while output empty");

    // skid fills only on a stalled output
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(m_tvalid && !m_tready))
        else $error("skid register filled without stall");

    // non-real results carry no roots and no saturation
    a_nonreal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[1:0] != STAT_REAL))
        |-> ((m_tdata == '0) && !m_tuser[2]))
        else $error("non-real result with nonzero roots");
`endif

endmodule

FILE: verif/tb_neutrino_pz_from_w_mass.sv
// ----------------------------------------------------------------------------
// tb_neutrino_pz_from_w_mass
// self-checking bench: directed and random lepton/met transactions are sent
// through the stream input, the expected neutrino pz roots are computed here
// with exact wide integer arithmetic and compared field by field at the output
// ----------------------------------------------------------------------------
module tb_neutrino_pz_from_w_mass;
    import nupz_pkg::*;

    // expected result of one transaction
    typedef struct packed
    {
        logic signed [OUT_BITS-1:0] pz_small;
        logic signed [OUT_BITS-1:0] pz_other;
        status_t                    status;
        logic                       saturated;
    } nu_result_t;

    localparam int LATENCY     = 70;
    localparam int CYCLE_LIMIT = 400000;

    logic                   clk;
    logic                   rst_n;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_W-1:0]      paddr;
    logic [DATA_W-1:0]      pwdata;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    // predictor copy of the w_mass register
    logic [W_BITS-1:0] w_mass_model;
    nu_result_t        expected_roots[$];
    int                error_count;
    int                cycle_count;
    // stall control for the receiver and idle gaps for the sender
    bit                sink_jitter;
    int                sink_hold_cycles;
    int                sink_burst;
    bit                send_jitter;

    neutrino_pz_from_w_mass uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // rounded, clipped quotient of a signed magnitude by 2*p
    function automatic logic [OUT_BITS-1:0] round_root(input bit neg,
        input logic [127:0] mag, input logic [127:0] p, inout bit sat);
        logic [127:0] q;
        logic [127:0] limit;
        begin
            q     = (mag + p) / (p << 1);
            limit = neg ? 128'd8388608 : 128'd8388607;
            if (q > limit)
            begin
                q   = limit;
                sat = 1'b1;
            end
            round_root = neg ? OUT_BITS'(-q) : OUT_BITS'(q);
        end
    endfunction

    // integer square root of a wide value, one bit per step
    function automatic logic [127:0] isqrt(input logic [127:0] d);
        logic [127:0] res;
        logic [127:0] cand;
        begin
            res = '0;
            for (int b = 63; b >= 0; b--)
            begin
                cand = res | (128'd1 << b);
                if (cand * cand <= d)
                    res = cand;
            end
            isqrt = res;
        end
    endfunction

    function automatic nu_result_t predict_neutrino_pz(
        input logic signed [MOM_BITS-1:0] lpx, input logic signed [MOM_BITS-1:0] lpy,
        input logic signed [MOM_BITS-1:0] lpz, input logic [MOM_BITS-1:0] en,
        input logic signed [MOM_BITS-1:0] mpx, input logic signed [MOM_BITS-1:0] mpy);
        nu_result_t   r;
        logic signed [127:0] lam2;
        logic signed [127:0] cs;
        logic [127:0] pt_lep;
        logic [127:0] pt_met;
        logic [127:0] lam_sq;
        logic [127:0] four_pm;
        logic [127:0] rt;
        logic [127:0] cmag;
        logic [127:0] big_mag;
        logic [127:0] small_mag;
        bit           cneg;
        bit           small_neg;
        bit           sat;
        begin
            r      = '0;
            r.status = STAT_REAL;
            sat    = 1'b0;
            pt_lep = 128'(lpx) * 128'(lpx) + 128'(lpy) * 128'(lpy);
            pt_met = 128'(mpx) * 128'(mpx) + 128'(mpy) * 128'(mpy);
            lam2   = 128'(w_mass_model) * 128'(w_mass_model)
                     + 2 * (128'(lpx) * 128'(mpx) + 128'(lpy) * 128'(mpy));
            if (pt_lep == 0)
            begin
                r.status = STAT_PT_ZERO;
                return r;
            end
            lam_sq  = 128'(lam2 * lam2);
            four_pm = 4 * pt_lep * pt_met;
            if (en == 0 || lam_sq <= four_pm)
            begin
                r.status = STAT_COMPLEX;
                return r;
            end
            rt   = 128'(en) * isqrt(lam_sq - four_pm);
            cs   = lam2 * 128'(lpz);
            cneg = cs < 0;
            cmag = cneg ? 128'(-cs) : 128'(cs);
            big_mag = cmag + rt;
            if (cmag >= rt)
            begin
                small_mag = cmag - rt;
                small_neg = cneg;
            end
            else
            begin
                small_mag = rt - cmag;
                small_neg = !cneg;
            end
            if (small_mag == 0)
                small_neg = 1'b0;
            r.pz_small  = round_root(small_neg, small_mag, pt_lep, sat);
            r.pz_other  = round_root(cneg, big_mag, pt_lep, sat);
            r.saturated = sat;
            return r;
        end
    endfunction

    // send one transaction, predicted at acceptance
    task automatic send_event(input logic [MOM_BITS-1:0] lpx, input logic [MOM_BITS-1:0] lpy,
        input logic [MOM_BITS-1:0] lpz, input logic [MOM_BITS-1:0] en,
        input logic [MOM_BITS-1:0] mpx, input logic [MOM_BITS-1:0] mpy);
        int gap;
        begin
            if (send_jitter && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 5);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tdata  <= IN_TDATA_W'({mpy, mpx, en, lpz, lpy, lpx});
            s_tvalid <= 1'b1;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            expected_roots.insert(expected_roots.size(),
                                  predict_neutrino_pz(lpx, lpy, lpz, en, mpx, mpy));
            @(negedge clk);
        end
    endtask

    task automatic drain_pipeline();
        begin
            s_tvalid <= 1'b0;
            while (expected_roots.size() != 0)
                @(negedge clk);
            repeat (LATENCY + 10) @(negedge clk);
        end
    endtask

    // register write, only while the block is idle
    task automatic write_w_mass(input logic [W_BITS-1:0] value);
        begin
            drain_pipeline();
            psel    <= 1'b1;
            pwrite  <= 1'b1;
            paddr   <= {REG_W_MASS, 2'b00};
            pwdata  <= DATA_W'(value);
            @(negedge clk);
            penable <= 1'b1;
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            w_mass_model = value;
        end
    endtask

    function automatic logic [MOM_BITS-1:0] rand_mom();
        begin
            case ($urandom_range(0, 3))
                0: rand_mom = MOM_BITS'($urandom);
                1: rand_mom = MOM_BITS'($urandom_range(0, 2000));
                2: rand_mom = MOM_BITS'(-$urandom_range(0, 2000));
                default: rand_mom = MOM_BITS'($urandom_range(0, 255) - 128);
            endcase
        end
    endfunction

    task automatic send_random_event();
        logic [MOM_BITS-1:0] en;
        begin
            en = ($urandom_range(0, 1) == 0) ? MOM_BITS'($urandom)
                                               : MOM_BITS'($urandom_range(1, 4000));
            send_event(rand_mom(), rand_mom(), rand_mom(), en, rand_mom(), rand_mom());
        end
    endtask

    // field extremes, zero pt, zero energy, complex and saturating cases
    task automatic test_directed();
        localparam logic [MOM_BITS-1:0] MAXP = {1'b0, {(MOM_BITS-1){1'b1}}};
        localparam logic [MOM_BITS-1:0] MINP = {1'b1, {(MOM_BITS-1){1'b0}}};
        localparam logic [MOM_BITS-1:0] EMAX = '1;
        begin
            send_event(0, 0, 100, 500, 30, 40);          // lepton pt zero
            send_event(0, 0, MINP, EMAX, MAXP, MINP);
            send_event(100, 0, 50, 0, 50, 0);            // zero energy
            send_event(16, 0, 0, 16, 2000, 0);           // lepton pz zero
            send_event(MAXP, MAXP, MAXP, EMAX, MINP, MINP);
            send_event(MINP, MINP, MINP, EMAX, MAXP, MAXP);
            send_event(MINP, MINP, MAXP, EMAX, MINP, MINP);
            send_event(1, 0, MAXP, EMAX, 0, 0);          // saturating roots
            send_event(1, 0, MINP, EMAX, 0, 0);
            send_event(0, 1, 0, EMAX, 0, 0);             // pz zero, tied order
            send_event(400, 300, 0, 800, 0, 0);
            send_event(400, 300, 1000, 1100, 200, -100);
            send_event(-400, 300, -1000, 1100, 200, 100);
            send_event(500, 0, 200, 600, 300, 0);
            send_event(-500, 0, 200, 600, 300, 0);       // negative lepton px
            send_event(MAXP, 0, 0, 1, MINP, 0);
            send_event(1, 1, 1, 1, 1, 1);
        end
    endtask

    task automatic test_w_mass_settings();
        begin
            write_w_mass('0);
            repeat (60) send_random_event();
            write_w_mass('1);
            repeat (60) send_random_event();
            write_w_mass(12'd7);
            repeat (40) send_random_event();
            write_w_mass(W_RESET);
        end
    endtask

    // receiver holds off long enough to back up the pipeline
    task automatic test_backpressure();
        begin
            sink_hold_cycles = 150;
            repeat (120) send_random_event();
            drain_pipeline();
        end
    endtask

    task automatic test_random();
        begin
            write_w_mass(12'($urandom_range(0, 4095)));
            repeat (400) send_random_event();
            write_w_mass(W_RESET);
            repeat (400) send_random_event();
            // last stretch with no idling on either side
            send_jitter = 1'b0;
            sink_jitter = 1'b0;
            repeat (150) send_random_event();
        end
    endtask

    // receiver side: random stall bursts and one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (sink_hold_cycles > 0)
        begin
            m_tready         <= 1'b0;
            sink_hold_cycles <= sink_hold_cycles - 1;
        end
        else if (sink_burst > 0)
        begin
            m_tready   <= 1'b0;
            sink_burst <= sink_burst - 1;
        end
        else if (sink_jitter && $urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            sink_burst <= $urandom_range(0, 4);
        end
        else
            m_tready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        nu_result_t exp_r;
        nu_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.pz_small  = m_tdata[OUT_BITS-1:0];
            got.pz_other  = m_tdata[2*OUT_BITS-1:OUT_BITS];
            got.status    = status_t'(m_tuser[1:0]);
            got.saturated = m_tuser[2];
            if (expected_roots.size() == 0)
            begin
                $error("unexpected result transaction");
                error_count++;
            end
            else
            begin
                exp_r = expected_roots.pop_front();
                if (got.pz_small !== exp_r.pz_small)
                begin
                    $error("pz_small expected %0d actual %0d", exp_r.pz_small, got.pz_small);
                    error_count++;
                end
                if (got.pz_other !== exp_r.pz_other)
                begin
                    $error("pz_other expected %0d actual %0d", exp_r.pz_other, got.pz_other);
                    error_count++;
                end
                if (got.status !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status, got.status);
                    error_count++;
                end
                if (got.saturated !== exp_r.saturated)
                begin
                    $error("saturated expected %0d actual %0d",
                           exp_r.saturated, got.saturated);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        error_count      = 0;
        cycle_count      = 0;
        sink_jitter      = 1'b1;
        send_jitter      = 1'b1;
        sink_hold_cycles = 0;
        w_mass_model     = W_RESET;
        rst_n    = 1'b0;
        s_tdata  = '0;
        s_tvalid = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_w_mass_settings();
        test_backpressure();
        test_random();
        drain_pipeline();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
